// ----- src/cbmsi_pkg.sv -----
// ----------------------------------------------------------------------------
// cbmsi_pkg
// types, codes and the security table of the cartridge bank mapper
// ----------------------------------------------------------------------------
package cbmsi_pkg;

  // item kinds
  localparam logic [2:0] FUNC_CPU_WRITE     = 3'd0;
  localparam logic [2:0] FUNC_LOW_READ      = 3'd1;
  localparam logic [2:0] FUNC_SCAN_TICK     = 3'd2;
  localparam logic [2:0] FUNC_PRG_TRANSLATE = 3'd3;
  localparam logic [2:0] FUNC_CHR_TRANSLATE = 3'd4;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_GAME_PATCH      = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_PRG_BANK_COUNT  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_CHR_ROM_PRESENT = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_FOUR_SCREEN     = 3'd3;
  localparam int unsigned CfgDataW = 9;

  // game patch codes
  localparam logic [2:0] PATCH_STANDARD   = 3'd0;
  localparam logic [2:0] PATCH_ZERO_AFTER = 3'd1;
  localparam logic [2:0] PATCH_ONE_AFTER  = 3'd2;
  localparam logic [2:0] PATCH_SEQ_TABLE  = 3'd3;
  localparam logic [2:0] PATCH_SEQ_MAGIC  = 3'd4;

  // register decode, addr & 0xE001
  localparam logic [15:0] DECODE_MASK      = 16'hE001;
  localparam logic [15:0] DEC_BANK_SELECT  = 16'h8000;
  localparam logic [15:0] DEC_BANK_DATA    = 16'h8001;
  localparam logic [15:0] DEC_MIRRORING    = 16'hA000;
  localparam logic [15:0] DEC_SAVE_RAM     = 16'hA001;
  localparam logic [15:0] DEC_IRQ_COUNT    = 16'hC000;
  localparam logic [15:0] DEC_IRQ_RELOAD   = 16'hC001;
  localparam logic [15:0] DEC_IRQ_DISABLE  = 16'hE000;
  localparam logic [15:0] DEC_IRQ_ENABLE   = 16'hE001;

  // bank data targets, bank_select[2:0]
  localparam logic [2:0] TGT_CHR_PAIR0   = 3'd0;
  localparam logic [2:0] TGT_CHR_PAIR1   = 3'd1;
  localparam logic [2:0] TGT_CHR_SINGLE0 = 3'd2;
  localparam logic [2:0] TGT_CHR_SINGLE1 = 3'd3;
  localparam logic [2:0] TGT_CHR_SINGLE2 = 3'd4;
  localparam logic [2:0] TGT_CHR_SINGLE3 = 3'd5;
  localparam logic [2:0] TGT_PRG_A       = 3'd6;
  localparam logic [2:0] TGT_PRG_B       = 3'd7;

  // security ports and values
  localparam logic [15:0] SEC_RESET_ADDR = 16'h5E00;
  localparam logic [15:0] SEC_STEP_ADDR  = 16'h5E01;
  localparam logic [7:0]  SEC_MAGIC_IDX  = 8'h09;
  localparam logic [7:0]  SEC_MAGIC_HIT  = 8'h6F;
  localparam logic [7:0]  SEC_MAGIC_MISS = 8'hB4;
  localparam logic [7:0]  SEC_MAGIC_INIT = 8'hFF;

  localparam logic [8:0] LAST_VISIBLE_LINE = 9'd239;

  typedef struct packed {
    logic [2:0]  func;
    logic [15:0] addr;
    logic [7:0]  data;
    logic [8:0]  scanline;
    logic        rendering_on;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [7:0] bank_number;
    logic       mirror_horizontal;
    logic       save_ram_enabled;
    logic       irq_pulse;
  } out_item_t;

  function automatic logic [7:0] seq_table_byte(input logic [4:0] idx);
    logic [7:0] v;
    case (idx)
      5'd0:  v = 8'hff;  5'd1:  v = 8'hbf;  5'd2:  v = 8'hb7;  5'd3:  v = 8'h97;
      5'd4:  v = 8'h97;  5'd5:  v = 8'h17;  5'd6:  v = 8'h57;  5'd7:  v = 8'h4f;
      5'd8:  v = 8'h6f;  5'd9:  v = 8'h6b;  5'd10: v = 8'heb;  5'd11: v = 8'ha9;
      5'd12: v = 8'hb1;  5'd13: v = 8'h90;  5'd14: v = 8'h94;  5'd15: v = 8'h14;
      5'd16: v = 8'h56;  5'd17: v = 8'h4e;  5'd18: v = 8'h6f;  5'd19: v = 8'h6b;
      5'd20: v = 8'heb;  5'd21: v = 8'ha9;  5'd22: v = 8'hb1;  5'd23: v = 8'h90;
      5'd24: v = 8'hd4;  5'd25: v = 8'h5c;  5'd26: v = 8'h3e;  5'd27: v = 8'h26;
      5'd28: v = 8'h87;  5'd29: v = 8'h83;  5'd30: v = 8'h13;  5'd31: v = 8'h00;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

// ----- src/cartridge_bank_mapper_scanline_irq_top.sv -----
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_scanline_irq_top
// bank mapper with register writes, security reads, address translation and
// a scanline interrupt counter
// ----------------------------------------------------------------------------
// Usage: every input beat is one item (CPU write, low read, scanline tick,
// program or pattern translation) and yields exactly one result beat. The
// block takes one item per clock cycle while the result register is not stalled.
// An accepted item is captured in the input register and then, once the
// result register is free, its result is registered there. The whole mapper
// state update is a single pass of logic between the input register and the
// result register. A stalled result register holds its beat while the input
// register still takes one more item. Configuration writes are taken at any
// time (cfg_ready_o is always high) and should only be issued while no item
// is in flight; writing chr_rom_present as zero clears every pattern bank
// register. Indexes beyond the register list are ignored.
module cartridge_bank_mapper_scanline_irq_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  cbmsi_pkg::in_item_t           in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output cbmsi_pkg::out_item_t          out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [cbmsi_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [cbmsi_pkg::CfgDataW-1:0] cfg_data_i
);
  import cbmsi_pkg::*;

  // configuration registers
  // pattern rom presence only matters at the moment it is written
  logic [2:0] game_patch_q;
  logic [8:0] prg_bank_count_q;
  logic       four_screen_q;

  // mapper state
  logic [7:0] bank_select_q, bank_select_d;
  logic [7:0] prg_bank_a_q, prg_bank_a_d;
  logic [7:0] prg_bank_b_q, prg_bank_b_d;
  logic [7:0] chr_pair_q [2];
  logic [7:0] chr_pair_d [2];
  logic [7:0] chr_single_q [4];
  logic [7:0] chr_single_d [4];
  logic [7:0] irq_count_q, irq_count_d;
  logic [7:0] irq_reload_q, irq_reload_d;
  logic       irq_on_q, irq_on_d;
  logic [7:0] sec_index_q, sec_index_d;
  logic       mirror_q, mirror_d;
  logic       save_ram_q, save_ram_d;

  // input register and result register
  logic      s1_valid_q;
  in_item_t  s1_item_q;
  logic      out_valid_q;
  out_item_t out_item_q;
  out_item_t res;

  logic s1_advance;
  logic cfg_write;
  logic chr_clear;

  // the result register frees up when empty or when its beat is taken
  assign s1_advance  = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !s1_valid_q || s1_advance;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_item_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;
  assign chr_clear   = cfg_write && (cfg_index_i == CFG_CHR_ROM_PRESENT) && !cfg_data_i[0];

  // working signals of the single-pass update
  logic [15:0] dec;
  logic [7:0]  cnt_dec;
  logic        fire;
  logic [7:0]  prg_last, prg_second;
  logic [1:0]  prg_win;
  logic [2:0]  chr_win;
  logic [8:0]  cnt_minus1, cnt_minus2;

  assign dec        = s1_item_q.addr & DECODE_MASK;
  assign cnt_dec    = irq_count_q - 8'd1;
  assign cnt_minus1 = prg_bank_count_q - 9'd1;
  assign cnt_minus2 = prg_bank_count_q - 9'd2;
  assign prg_last   = cnt_minus1[7:0];
  assign prg_second = cnt_minus2[7:0];
  assign prg_win    = s1_item_q.addr[14:13];
  assign chr_win    = s1_item_q.addr[12:10] ^ {bank_select_q[7], 2'b00};

  always_comb begin
    bank_select_d = bank_select_q;
    prg_bank_a_d  = prg_bank_a_q;
    prg_bank_b_d  = prg_bank_b_q;
    chr_pair_d    = chr_pair_q;
    chr_single_d  = chr_single_q;
    irq_count_d   = irq_count_q;
    irq_reload_d  = irq_reload_q;
    irq_on_d      = irq_on_q;
    sec_index_d   = sec_index_q;
    mirror_d      = mirror_q;
    save_ram_d    = save_ram_q;
    fire          = 1'b0;

    res.read_data   = 8'h00;
    res.bank_number = 8'h00;
    res.irq_pulse   = 1'b0;

    if (s1_advance) begin
      case (s1_item_q.func)
        FUNC_CPU_WRITE: begin
          case (dec)
            DEC_BANK_SELECT: bank_select_d = s1_item_q.data;
            DEC_BANK_DATA: begin
              case (bank_select_q[2:0])
                TGT_CHR_PAIR0:   chr_pair_d[0]   = s1_item_q.data & 8'hfe;
                TGT_CHR_PAIR1:   chr_pair_d[1]   = s1_item_q.data & 8'hfe;
                TGT_CHR_SINGLE0: chr_single_d[0] = s1_item_q.data;
                TGT_CHR_SINGLE1: chr_single_d[1] = s1_item_q.data;
                TGT_CHR_SINGLE2: chr_single_d[2] = s1_item_q.data;
                TGT_CHR_SINGLE3: chr_single_d[3] = s1_item_q.data;
                TGT_PRG_A:       prg_bank_a_d    = s1_item_q.data;
                TGT_PRG_B:       prg_bank_b_d    = s1_item_q.data;
                default:         prg_bank_b_d    = s1_item_q.data;
              endcase
            end
            DEC_MIRRORING: begin
              if (!four_screen_q) mirror_d = s1_item_q.data[0];
            end
            DEC_SAVE_RAM:    save_ram_d   = s1_item_q.data[7];
            DEC_IRQ_COUNT:   irq_count_d  = s1_item_q.data;
            DEC_IRQ_RELOAD:  irq_reload_d = s1_item_q.data;
            DEC_IRQ_DISABLE: irq_on_d     = 1'b0;
            DEC_IRQ_ENABLE:  irq_on_d     = 1'b1;
            default: ;
          endcase
        end
        FUNC_LOW_READ: begin
          res.read_data = s1_item_q.addr[15:8];
          if (game_patch_q == PATCH_SEQ_TABLE) begin
            if (s1_item_q.addr == SEC_RESET_ADDR) begin
              sec_index_d   = 8'h00;
              res.read_data = 8'h00;
            end else if (s1_item_q.addr == SEC_STEP_ADDR) begin
              res.read_data = seq_table_byte(sec_index_q[4:0]);
              sec_index_d   = sec_index_q + 8'd1;
            end
          end else if (game_patch_q == PATCH_SEQ_MAGIC) begin
            if (s1_item_q.addr == SEC_RESET_ADDR) begin
              sec_index_d   = 8'h00;
              res.read_data = SEC_MAGIC_INIT;
            end else if (s1_item_q.addr == SEC_STEP_ADDR) begin
              res.read_data = (sec_index_q == SEC_MAGIC_IDX) ? SEC_MAGIC_HIT
                                                             : SEC_MAGIC_MISS;
              sec_index_d   = sec_index_q + 8'd1;
            end
          end
        end
        FUNC_SCAN_TICK: begin
          if (irq_on_q && (s1_item_q.scanline <= LAST_VISIBLE_LINE) &&
              s1_item_q.rendering_on) begin
            irq_count_d = cnt_dec;
            // the patched variants test the value after the decrement
            case (game_patch_q)
              PATCH_ZERO_AFTER: fire = (cnt_dec == 8'h00);
              PATCH_ONE_AFTER:  fire = (cnt_dec == 8'h01);
              default:          fire = (irq_count_q == 8'h00);
            endcase
            if (fire) irq_count_d = irq_reload_q;
            res.irq_pulse = fire;
          end
        end
        FUNC_PRG_TRANSLATE: begin
          if (s1_item_q.addr[15]) begin
            case (prg_win)
              2'd3:    res.bank_number = prg_last;
              2'd1:    res.bank_number = prg_bank_b_q;
              2'd0:    res.bank_number = bank_select_q[6] ? prg_second : prg_bank_a_q;
              default: res.bank_number = bank_select_q[6] ? prg_bank_a_q : prg_second;
            endcase
          end
        end
        FUNC_CHR_TRANSLATE: begin
          if (!chr_win[2]) begin
            res.bank_number = chr_pair_q[chr_win[1]] + {7'd0, chr_win[0]};
          end else begin
            res.bank_number = chr_single_q[chr_win[1:0]];
          end
        end
        default: ;
      endcase
    end

    // removing pattern rom wipes the pattern banks
    if (chr_clear) begin
      chr_pair_d[0]   = 8'h00;
      chr_pair_d[1]   = 8'h00;
      chr_single_d[0] = 8'h00;
      chr_single_d[1] = 8'h00;
      chr_single_d[2] = 8'h00;
      chr_single_d[3] = 8'h00;
    end

    // mirroring and save-ram report the state after the step
    res.mirror_horizontal = mirror_d;
    res.save_ram_enabled  = save_ram_d;
  end

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      game_patch_q      <= PATCH_STANDARD;
      prg_bank_count_q  <= 9'd2;
      four_screen_q     <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index_i)
        CFG_GAME_PATCH:      game_patch_q      <= cfg_data_i[2:0];
        CFG_PRG_BANK_COUNT:  prg_bank_count_q  <= cfg_data_i;
        CFG_CHR_ROM_PRESENT: ;    // handled by chr_clear
        CFG_FOUR_SCREEN:     four_screen_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // mapper state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_select_q   <= 8'h00;
      prg_bank_a_q    <= 8'h00;
      prg_bank_b_q    <= 8'h01;
      chr_pair_q[0]   <= 8'h00;
      chr_pair_q[1]   <= 8'h02;
      chr_single_q[0] <= 8'h04;
      chr_single_q[1] <= 8'h05;
      chr_single_q[2] <= 8'h06;
      chr_single_q[3] <= 8'h07;
      irq_count_q     <= 8'h00;
      irq_reload_q    <= 8'h00;
      irq_on_q        <= 1'b0;
      sec_index_q     <= 8'h00;
      mirror_q        <= 1'b0;
      save_ram_q      <= 1'b0;
    end else begin
      bank_select_q <= bank_select_d;
      prg_bank_a_q  <= prg_bank_a_d;
      prg_bank_b_q  <= prg_bank_b_d;
      chr_pair_q    <= chr_pair_d;
      chr_single_q  <= chr_single_d;
      irq_count_q   <= irq_count_d;
      irq_reload_q  <= irq_reload_d;
      irq_on_q      <= irq_on_d;
      sec_index_q   <= sec_index_d;
      mirror_q      <= mirror_d;
      save_ram_q    <= save_ram_d;
    end
  end

  // pipeline control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) s1_valid_q <= in_valid_i;
      if (s1_advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // beat payloads
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) s1_item_q <= in_data_i;
    if (s1_advance) out_item_q <= res;
  end

  // every item leaving the input register lands in the result register
  a_advance_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_advance |=> out_valid_o)
    else $error("item left input register without a result beat");

  // back-pressure only while the input register holds an item
  a_stall_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_valid_q)
    else $error("input stalled with empty input register");

  // an irq pulse comes only from a tick, never with read or bank data
  a_pulse_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.irq_pulse) |->
      (out_data_o.read_data == 8'h00 && out_data_o.bank_number == 8'h00))
    else $error("irq pulse together with read or bank data");

  // removing pattern rom clears the pattern banks on the next edge
  a_chr_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chr_clear |=> (chr_pair_q[0] == 8'h00 && chr_pair_q[1] == 8'h00 &&
                   chr_single_q[0] == 8'h00 && chr_single_q[3] == 8'h00))
    else $error("pattern banks not cleared");

  // the counter only moves when an item is processed
  a_count_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_advance |=> $stable(irq_count_q))
    else $error("irq counter moved without an item");

endmodule
